// ===== rtl/wfo_pkg.sv =====
// ----------------------------------------------------------------------------
// wfo_pkg
// Shared types and fixed constants of the wavetable folding oscillator.
// ----------------------------------------------------------------------------
package wfo_pkg;

   localparam int CMD_W      = 2;
   localparam int VALUE_W    = 16;
   localparam int CV_W       = 10;
   localparam int DAC_W      = 8;
   localparam int PERIOD_W   = 9;
   localparam int INC_W      = 4;
   localparam int RSP_DATA_W = 24;

   localparam logic [CV_W-1:0]     CV_MAX     = 10'd1023;
   localparam logic [DAC_W-1:0]    FOLD_LOW   = 8'd128;
   localparam logic [DAC_W-1:0]    FOLD_HIGH  = 8'd255;
   localparam int                  FOLD_SPAN  = 127;
   localparam logic [INC_W-1:0]    INC_MAX    = 4'd15;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = 9'd511;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_PITCH = 2'd1,
      CMD_FOLD  = 2'd2,
      CMD_NOTE  = 2'd3
   } cmd_type;

   // classified request handed from front to back
   typedef struct packed {
      cmd_type              kind;
      logic [VALUE_W-1:0]   value;
   } op_type;

   typedef struct packed {
      logic [INC_W-1:0]     phase_increment;
      logic [PERIOD_W-1:0]  timer_period;
      logic [DAC_W-1:0]     dac_sample;
   } rsp_type;

endpackage

// ===== rtl/wfo_queue.sv =====
// ----------------------------------------------------------------------------
// wfo_queue
// Two-entry queue between the request front end and the back end.
// ----------------------------------------------------------------------------
module wfo_queue #(
   parameter int WIDTH = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/wfo_front.sv =====
// ----------------------------------------------------------------------------
// wfo_front
// Accepts requests, applies CV hysteresis, mode and note range filtering, and queues
// only the requests that change something or produce a sample.
// ----------------------------------------------------------------------------
module wfo_front #(
   parameter int LOW_FREQ      = 20,
   parameter int HIGH_FREQ     = 1000,
   parameter int CV_HYSTERESIS = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_wdata,
   input  logic                        req_valid,
   input  wfo_pkg::cmd_type            req_command,
   input  logic [wfo_pkg::VALUE_W-1:0] req_value,
   output logic                        req_ready,
   input  logic                        queue_ready,
   output logic                        push,
   output wfo_pkg::op_type             push_op
);

   localparam logic [wfo_pkg::CV_W-1:0]    HYST   = wfo_pkg::CV_W'(CV_HYSTERESIS);
   localparam logic [wfo_pkg::VALUE_W-1:0] LOW_V  = wfo_pkg::VALUE_W'(LOW_FREQ);
   localparam logic [wfo_pkg::VALUE_W-1:0] HIGH_V = wfo_pkg::VALUE_W'(HIGH_FREQ);

   logic                     note_mode_ff, note_mode_in;
   logic [wfo_pkg::CV_W-1:0] last_pitch_ff, last_pitch_in;
   logic [wfo_pkg::CV_W-1:0] last_fold_ff, last_fold_in;

   logic                     accept;
   logic                     keep;
   logic [wfo_pkg::CV_W-1:0] cv;
   logic [wfo_pkg::CV_W-1:0] pitch_diff;
   logic [wfo_pkg::CV_W-1:0] fold_diff;
   logic                     pitch_moved;
   logic                     fold_moved;

   assign req_ready = queue_ready;
   assign accept    = req_valid && queue_ready;

   always_comb begin
      if (req_value > wfo_pkg::VALUE_W'(wfo_pkg::CV_MAX)) begin
         cv = wfo_pkg::CV_MAX;
      end else begin
         cv = req_value[wfo_pkg::CV_W-1:0];
      end
      pitch_diff  = (cv > last_pitch_ff) ? cv - last_pitch_ff : last_pitch_ff - cv;
      fold_diff   = (cv > last_fold_ff) ? cv - last_fold_ff : last_fold_ff - cv;
      pitch_moved = pitch_diff > HYST;
      fold_moved  = fold_diff > HYST;
   end

   always_comb begin
      note_mode_in  = csr_we ? csr_wdata : note_mode_ff;
      last_pitch_in = last_pitch_ff;
      last_fold_in  = last_fold_ff;
      keep          = 1'b0;
      push_op.kind  = req_command;
      push_op.value = wfo_pkg::VALUE_W'(cv);
      case (req_command)
         wfo_pkg::CMD_TICK: begin
            keep = 1'b1;
         end
         wfo_pkg::CMD_PITCH: begin
            keep = !note_mode_ff && pitch_moved;
            if (accept && keep) begin
               last_pitch_in = cv;
            end
         end
         wfo_pkg::CMD_FOLD: begin
            keep = fold_moved;
            if (accept && keep) begin
               last_fold_in = cv;
            end
         end
         wfo_pkg::CMD_NOTE: begin
            keep          = note_mode_ff && (req_value >= LOW_V) && (req_value <= HIGH_V);
            push_op.value = req_value;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      push = accept && keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_mode_ff  <= 1'b0;
         last_pitch_ff <= '0;
         last_fold_ff  <= '0;
      end else begin
         note_mode_ff  <= note_mode_in;
         last_pitch_ff <= last_pitch_in;
         last_fold_ff  <= last_fold_in;
      end
   end

endmodule

// ===== rtl/wfo_div.sv =====
// ----------------------------------------------------------------------------
// wfo_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wfo_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic             fits;

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

// ===== rtl/wfo_back.sv =====
// ----------------------------------------------------------------------------
// wfo_back
// Carries out queued operations: phase stepping, table lookup and folding,
// CV mapping, and the frequency to increment/period search at phase wrap.
// ----------------------------------------------------------------------------
module wfo_back #(
   parameter int TABLE_DEPTH    = 1024,
   parameter int TIMER_CLOCK_HZ = 10000000,
   parameter int LOW_FREQ       = 20,
   parameter int HIGH_FREQ      = 1000,
   parameter int LEAST_PERIOD   = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   input  wfo_pkg::op_type  op,
   output logic             op_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wfo_pkg::rsp_type rsp
);

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int FREQ_W  = $clog2(HIGH_FREQ + 1);
   localparam int CLK_W   = $clog2(TIMER_CLOCK_HZ + 1);
   localparam int SPAN    = HIGH_FREQ - LOW_FREQ;
   localparam int SPAN_W  = $clog2(SPAN + 1);
   localparam int FSPAN_W = $clog2(wfo_pkg::FOLD_SPAN + 1);
   localparam int MAP_W   = wfo_pkg::CV_W + ((SPAN_W > FSPAN_W) ? SPAN_W : FSPAN_W);
   localparam int DIV_W   = (CLK_W > MAP_W) ? CLK_W : MAP_W;
   localparam int DEN_W   = $clog2(TABLE_DEPTH * HIGH_FREQ + 1);
   localparam int ACC_W   = DIV_W + wfo_pkg::INC_W;
   localparam int INC_W   = wfo_pkg::INC_W;

   // table entry i*256/DEPTH computed as i*RECIP >> (RECIP_SHIFT-8), exact for 12-bit i
   localparam int          RECIP_SHIFT  = 32;
   localparam logic [63:0] RECIP        = ((64'd1 << RECIP_SHIFT) + 64'(TABLE_DEPTH) - 64'd1)
                                          / 64'(TABLE_DEPTH);
   localparam int          RECIP_W      = $clog2(RECIP + 64'd1);
   localparam int          PROD_W       = ADDR_W + RECIP_W;
   localparam int          SAMPLE_SHIFT = RECIP_SHIFT - wfo_pkg::DAC_W;

   // cv*span/1023 as cv*span*MAP_RECIP >> MAP_SHIFT, exact for products below 2^22
   localparam int          MAP_SHIFT = 32;
   localparam logic [63:0] MAP_RECIP = ((64'd1 << MAP_SHIFT) + 64'(wfo_pkg::CV_MAX) - 64'd1)
                                       / 64'(wfo_pkg::CV_MAX);
   localparam int          MRECIP_W  = $clog2(MAP_RECIP + 64'd1);
   localparam int          MPROD_W   = MAP_W + MRECIP_W;
   localparam int          MQ_W      = MPROD_W - MAP_SHIFT;

   localparam logic [ADDR_W:0]  DEPTH_P   = (ADDR_W + 1)'(TABLE_DEPTH);
   localparam logic [DEN_W-1:0] DEPTH_D   = DEN_W'(TABLE_DEPTH);
   localparam logic [DIV_W-1:0] CLK_NUM   = DIV_W'(TIMER_CLOCK_HZ);
   localparam logic [MAP_W-1:0] SPAN_V    = MAP_W'(SPAN);
   localparam logic [MAP_W-1:0] FSPAN_V   = MAP_W'(wfo_pkg::FOLD_SPAN);
   localparam logic [FREQ_W-1:0] LOW_V    = FREQ_W'(LOW_FREQ);
   localparam logic [ACC_W-1:0] LEAST_V   = ACC_W'(LEAST_PERIOD);
   localparam logic [ACC_W-1:0] PMAX_V    = ACC_W'(wfo_pkg::PERIOD_MAX);
   localparam logic [INC_W-1:0] INC_LAST  = wfo_pkg::INC_MAX - INC_W'(1);

   typedef enum logic [6:0] {
      ST_INIT = 7'b0000001,
      ST_IDLE = 7'b0000010,
      ST_DIV  = 7'b0000100,
      ST_STEP = 7'b0001000,
      ST_MAP  = 7'b0010000,
      ST_LOOK = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      JOB_INIT  = 2'd0,
      JOB_TICK  = 2'd1,
      JOB_PITCH = 2'd2,
      JOB_FOLD  = 2'd3
   } job_type;

   state_type                  state_ff, state_in;
   job_type                    job_ff, job_in;
   logic [ADDR_W-1:0]          phase_ff, phase_in;
   logic [INC_W-1:0]           inc_ff, inc_in;
   logic [wfo_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [FREQ_W-1:0]          pf_ff, pf_in;
   logic                       pend_ff, pend_in;
   logic [wfo_pkg::DAC_W-1:0]  thr_ff, thr_in;
   logic [DIV_W-1:0]           q_ff, q_in;
   logic [DEN_W-1:0]           r_ff, r_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic [ACC_W-1:0]           acc_q_ff, acc_q_in;
   logic [DEN_W-1:0]           acc_r_ff, acc_r_in;
   logic [INC_W-1:0]           m_ff, m_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [MAP_W-1:0]           map_ff, map_in;
   wfo_pkg::rsp_type           rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       div_start;
   logic [DIV_W-1:0]           div_num;
   logic [DEN_W-1:0]           div_den;
   logic                       div_done;
   logic [DIV_W-1:0]           div_quo;
   logic [DEN_W-1:0]           div_rem;

   logic [DEN_W-1:0]           den_low;
   logic [DEN_W-1:0]           den_pend;
   logic [ADDR_W:0]            tick_sum;
   logic                       tick_wrap;
   logic [ADDR_W-1:0]          tick_next;
   logic [INC_W-1:0]           step_inc;
   logic [ADDR_W:0]            step_sum;
   logic [ADDR_W-1:0]          step_next;
   logic [DEN_W:0]             nr_raw;
   logic                       carry;
   logic [DEN_W-1:0]           nr;
   logic [ACC_W-1:0]           nq;
   logic                       stop;
   logic [wfo_pkg::DAC_W-1:0]  sample;
   logic [wfo_pkg::DAC_W-1:0]  folded;
   logic [MPROD_W-1:0]         map_prod;
   logic [MQ_W-1:0]            map_quo;

   wfo_div #(
      .NUM_W (DIV_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      den_low   = DEPTH_D * DEN_W'(LOW_V);
      den_pend  = DEPTH_D * DEN_W'(pf_ff);
      tick_sum  = {1'b0, phase_ff} + (ADDR_W + 1)'(inc_ff);
      tick_wrap = tick_sum >= DEPTH_P;
      tick_next = tick_wrap ? ADDR_W'(tick_sum - DEPTH_P) : tick_sum[ADDR_W-1:0];

      // accumulate floor(m*N/den) as m*Q + carries of m*R over den
      nr_raw    = {1'b0, acc_r_ff} + {1'b0, r_ff};
      carry     = nr_raw >= {1'b0, den_ff};
      nr        = carry ? DEN_W'(nr_raw - {1'b0, den_ff}) : nr_raw[DEN_W-1:0];
      nq        = acc_q_ff + ACC_W'(q_ff) + ACC_W'(carry);
      stop      = (nq >= LEAST_V) || (m_ff == INC_LAST);
      step_inc  = m_ff + INC_W'(1);
      step_sum  = {1'b0, phase_ff} + (ADDR_W + 1)'(step_inc);
      step_next = (step_sum >= DEPTH_P) ? ADDR_W'(step_sum - DEPTH_P)
                                        : step_sum[ADDR_W-1:0];

      sample    = prod_ff[SAMPLE_SHIFT +: wfo_pkg::DAC_W];
      folded    = (sample > thr_ff) ? thr_ff - (sample - thr_ff) : sample;

      map_prod  = MPROD_W'(map_ff) * MPROD_W'(MAP_RECIP);
      map_quo   = map_prod[MAP_SHIFT +: MQ_W];
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      phase_in     = phase_ff;
      inc_in       = inc_ff;
      period_in    = period_ff;
      pf_in        = pf_ff;
      pend_in      = pend_ff;
      thr_in       = thr_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      den_in       = den_ff;
      acc_q_in     = acc_q_ff;
      acc_r_in     = acc_r_ff;
      m_in         = m_ff;
      prod_in      = prod_ff;
      map_in       = map_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start    = 1'b0;
      div_num      = CLK_NUM;
      div_den      = den_low;
      op_pop       = 1'b0;

      case (state_ff)
         ST_INIT: begin
            div_start = 1'b1;
            den_in    = den_low;
            job_in    = JOB_INIT;
            state_in  = ST_DIV;
         end
         ST_IDLE: begin
            if (op_valid) begin
               op_pop = 1'b1;
               case (op.kind)
                  wfo_pkg::CMD_TICK: begin
                     if (tick_wrap && pend_ff && (pf_ff != '0)) begin
                        div_start = 1'b1;
                        div_den   = den_pend;
                        den_in    = den_pend;
                        job_in    = JOB_TICK;
                        pend_in   = 1'b0;
                        pf_in     = '0;
                        state_in  = ST_DIV;
                     end else begin
                        phase_in = tick_next;
                        state_in = ST_LOOK;
                     end
                  end
                  wfo_pkg::CMD_PITCH: begin
                     map_in   = MAP_W'(op.value[wfo_pkg::CV_W-1:0]) * SPAN_V;
                     job_in   = JOB_PITCH;
                     state_in = ST_MAP;
                  end
                  wfo_pkg::CMD_FOLD: begin
                     map_in   = MAP_W'(op.value[wfo_pkg::CV_W-1:0]) * FSPAN_V;
                     job_in   = JOB_FOLD;
                     state_in = ST_MAP;
                  end
                  wfo_pkg::CMD_NOTE: begin
                     pf_in   = op.value[FREQ_W-1:0];
                     pend_in = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               q_in     = div_quo;
               r_in     = div_rem;
               acc_q_in = '0;
               acc_r_in = '0;
               m_in     = INC_W'(1);
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (stop) begin
               inc_in    = step_inc;
               period_in = (nq > PMAX_V) ? wfo_pkg::PERIOD_MAX : nq[wfo_pkg::PERIOD_W-1:0];
               if (job_ff == JOB_TICK) begin
                  phase_in = step_next;
                  state_in = ST_LOOK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               acc_q_in = nq;
               acc_r_in = nr;
               m_in     = step_inc;
            end
         end
         ST_MAP: begin
            if (job_ff == JOB_PITCH) begin
               pf_in   = FREQ_W'(map_quo) + LOW_V;
               pend_in = 1'b1;
            end else begin
               thr_in  = wfo_pkg::DAC_W'(map_quo) + wfo_pkg::FOLD_LOW;
            end
            state_in = ST_IDLE;
         end
         ST_LOOK: begin
            prod_in  = PROD_W'(phase_ff) * PROD_W'(RECIP);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.dac_sample      = folded;
               rsp_in.timer_period    = period_ff;
               rsp_in.phase_increment = inc_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         job_ff       <= JOB_INIT;
         phase_ff     <= '0;
         inc_ff       <= '0;
         period_ff    <= '0;
         pf_ff        <= '0;
         pend_ff      <= 1'b0;
         thr_ff       <= wfo_pkg::FOLD_HIGH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         phase_ff     <= phase_in;
         inc_ff       <= inc_in;
         period_ff    <= period_in;
         pf_ff        <= pf_in;
         pend_ff      <= pend_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      r_ff     <= r_in;
      den_ff   <= den_in;
      acc_q_ff <= acc_q_in;
      acc_r_ff <= acc_r_in;
      m_ff     <= m_in;
      prod_ff  <= prod_in;
      map_ff   <= map_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// ===== rtl/wavetable_folding_oscillator_top.sv =====
// ----------------------------------------------------------------------------
// wavetable_folding_oscillator_top
// Wavetable oscillator with wavefolder: tick, CV and note requests in, one
// DAC sample with timer period and phase increment out per tick.
// ----------------------------------------------------------------------------
// Requests are filtered on entry (CV hysteresis, mode, note range) and queued
// in a two-entry queue; the back end takes one queued request at a time. A
// tick passes through the back end as phase step, table multiply, then fold
// and output register, which waits while an earlier sample is still stalled.
// A tick that wraps with a frequency change pending adds the divider, one bit
// a cycle over a max(clog2(TIMER_CLOCK_HZ+1), 10+span bits)-bit dividend (24
// bits at the defaults), plus one accumulate step per tried increment. A pitch
// or fold CV sample that passes hysteresis is scaled by a constant reciprocal
// multiply for the /1023 mapping; a note is stored as the pending frequency
// directly; filtered requests never reach the back end.
// After reset the back end works out the timing for LOW_FREQ before it takes
// requests; requests are queued meanwhile. The result register lets the back
// end move on while a sample waits on rsp_tready.
module wavetable_folding_oscillator_top #(
   parameter int TABLE_DEPTH    = 1024,
   parameter int TIMER_CLOCK_HZ = 10000000,
   parameter int LOW_FREQ       = 20,
   parameter int HIGH_FREQ      = 1000,
   parameter int LEAST_PERIOD   = 64,
   parameter int CV_HYSTERESIS  = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic                           csr_wdata,   // note_mode
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [wfo_pkg::VALUE_W-1:0]    req_tdata,   // [15:0] value
   input  logic [wfo_pkg::CMD_W-1:0]      req_tuser,   // [1:0] command
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] dac_sample, [16:8] timer_period, [20:17] phase_increment, rest zero
   output logic [wfo_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int RSP_W = $bits(wfo_pkg::rsp_type);
   localparam int OP_W  = $bits(wfo_pkg::op_type);

   logic             push;
   wfo_pkg::op_type  push_op;
   logic             queue_ready;
   logic             pop;
   logic             pop_valid;
   logic [OP_W-1:0]  pop_bits;
   wfo_pkg::rsp_type rsp;

   wfo_front #(
      .LOW_FREQ      (LOW_FREQ),
      .HIGH_FREQ     (HIGH_FREQ),
      .CV_HYSTERESIS (CV_HYSTERESIS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_tvalid),
      .req_command (wfo_pkg::cmd_type'(req_tuser)),
      .req_value   (req_tdata),
      .req_ready   (req_tready),
      .queue_ready (queue_ready),
      .push        (push),
      .push_op     (push_op)
   );

   wfo_queue #(
      .WIDTH (OP_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_op),
      .push_ready (queue_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_bits)
   );

   wfo_back #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .TIMER_CLOCK_HZ (TIMER_CLOCK_HZ),
      .LOW_FREQ       (LOW_FREQ),
      .HIGH_FREQ      (HIGH_FREQ),
      .LEAST_PERIOD   (LEAST_PERIOD)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (pop_valid),
      .op        (wfo_pkg::op_type'(pop_bits)),
      .op_pop    (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {{(wfo_pkg::RSP_DATA_W - RSP_W){1'b0}}, rsp};

endmodule

// ===== rtl/wfo_checker.sv =====
// ----------------------------------------------------------------------------
// wfo_checker
// Port-level checks of the oscillator result stream.
// ----------------------------------------------------------------------------
module wfo_checker #(
   parameter int LEAST_PERIOD = 64
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [wfo_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [wfo_pkg::PERIOD_W-1:0] LEAST_V = wfo_pkg::PERIOD_W'(LEAST_PERIOD);

   logic [wfo_pkg::INC_W-1:0]    inc_field;
   logic [wfo_pkg::PERIOD_W-1:0] period_field;

   assign inc_field    = rsp_tdata[20:17];
   assign period_field = rsp_tdata[16:8];

   // result register is cleared by reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_inc_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inc_field != '0)
      else $error("zero phase increment");

   // the increment search only stops short of the limit once the period is long enough
   a_period_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (inc_field != wfo_pkg::INC_MAX) |-> period_field >= LEAST_V)
      else $error("timer period below floor with increment under limit");

endmodule

bind wavetable_folding_oscillator_top wfo_checker #(
   .LEAST_PERIOD (LEAST_PERIOD)
) u_wfo_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
